[sv/mrrc_pkg.sv]
// ----------------------------------------------------------------------------
// Modbus RTU response checker package
// Shared types, sizes and the byte-wide CRC-16 update used by the checker.
// ----------------------------------------------------------------------------
`default_nettype none

package mrrc_pkg;

    // Only the first FRAME_BYTES bytes of a frame are counted.
    localparam int FRAME_BYTES = 256;
    localparam int CNT_W       = $clog2(FRAME_BYTES + 1);

    // Result queue between the frame logic and the output port.
    localparam int OQ_DEPTH = 4;
    localparam int OQ_PTR_W = $clog2(OQ_DEPTH);
    localparam int OQ_CNT_W = $clog2(OQ_DEPTH + 1);

    // CRC-16 constants.
    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    // Exception replies set the top bit of the function code.
    localparam logic [7:0] EXC_FLAG = 8'h80;

    // Configuration register indexes.
    localparam logic [1:0] CFG_EXPECTED_SLAVE    = 2'd0;
    localparam logic [1:0] CFG_EXPECTED_FUNCTION = 2'd1;
    localparam logic [1:0] CFG_PDU_LIMIT         = 2'd2;

    typedef enum logic [2:0] {
        ST_OK          = 3'd0,
        ST_SHORT       = 3'd1,
        ST_CRC_ERROR   = 3'd2,
        ST_WRONG_SLAVE = 3'd3,
        ST_EXCEPTION   = 3'd4,
        ST_WRONG_FUNC  = 3'd5
    } t_status;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       frame_end;
    } t_in;

    typedef struct packed {
        logic [7:0] pdu_byte;
        logic       is_status;
        t_status    status;
        logic [7:0] exception_code;
        logic [7:0] pdu_length;
    } t_out;

    typedef struct packed {
        logic [7:0] expected_slave;
        logic [6:0] expected_function;
        logic [7:0] pdu_limit;
    } t_cfg;

    // Results produced by one consumed byte: a PDU beat and/or a status beat.
    typedef struct packed {
        logic pdu_valid;
        logic status_valid;
        t_out pdu_res;
        t_out status_res;
    } t_push;

    // Reflected CRC-16 update over one byte, eight shift steps.
    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in,
                                             input logic [7:0]  data);
        logic [15:0] c;
        c = crc_in ^ {8'h00, data};
        for (int i = 0; i < 8; i++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

`default_nettype wire

[sv/mrrc_frame.sv]
// ----------------------------------------------------------------------------
// Modbus RTU response checker frame logic
// Tracks the frame position, holds back the last two bytes as the possible
// CRC, runs the CRC over the rest and decides the closing status.
// ----------------------------------------------------------------------------
`default_nettype none

module mrrc_frame (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_consume,
    input  wire mrrc_pkg::t_in  i_item,
    input  wire mrrc_pkg::t_cfg i_cfg,
    output mrrc_pkg::t_push     o_push
);

    logic [mrrc_pkg::CNT_W-1:0] r_byte_count, n_byte_count;
    logic [15:0]                r_crc, n_crc;
    logic [7:0]                 r_held0, n_held0;
    logic [7:0]                 r_held1, n_held1;
    logic [7:0]                 r_first, n_first;
    logic [7:0]                 r_second, n_second;
    logic [7:0]                 r_third, n_third;

    logic                       pdu_emit;
    logic [mrrc_pkg::CNT_W-1:0] len_full;
    logic [7:0]                 len_clamped;
    mrrc_pkg::t_status          st;
    logic [7:0]                 exc_code;
    logic [7:0]                 pdu_len;

    // Next frame state and the results of the byte being consumed.
    always_comb begin
        n_byte_count = r_byte_count;
        n_crc        = r_crc;
        n_held0      = r_held0;
        n_held1      = r_held1;
        n_first      = r_first;
        n_second     = r_second;
        n_third      = r_third;
        pdu_emit     = 1'b0;

        if (r_byte_count < mrrc_pkg::CNT_W'(mrrc_pkg::FRAME_BYTES)) begin
            // The oldest held byte leaves the hold and enters the CRC.
            if (r_byte_count >= mrrc_pkg::CNT_W'(2)) begin
                n_crc = mrrc_pkg::crc_byte(r_crc, r_held0);
                if ((r_byte_count >= mrrc_pkg::CNT_W'(3)) &&
                    ((r_byte_count - mrrc_pkg::CNT_W'(3)) <
                     mrrc_pkg::CNT_W'(i_cfg.pdu_limit))) begin
                    pdu_emit = 1'b1;
                end
            end
            n_held0 = r_held1;
            n_held1 = i_item.rx_byte;
            if (r_byte_count == mrrc_pkg::CNT_W'(0)) begin
                n_first = i_item.rx_byte;
            end
            if (r_byte_count == mrrc_pkg::CNT_W'(1)) begin
                n_second = i_item.rx_byte;
            end
            if (r_byte_count == mrrc_pkg::CNT_W'(2)) begin
                n_third = i_item.rx_byte;
            end
            n_byte_count = r_byte_count + mrrc_pkg::CNT_W'(1);
        end

        // Closing checks, in priority order, on the updated frame state.
        len_full = n_byte_count - mrrc_pkg::CNT_W'(3);
        if (len_full > mrrc_pkg::CNT_W'(i_cfg.pdu_limit)) begin
            len_clamped = i_cfg.pdu_limit;
        end else begin
            len_clamped = len_full[7:0];
        end

        exc_code = 8'h00;
        pdu_len  = 8'h00;
        if (n_byte_count < mrrc_pkg::CNT_W'(4)) begin
            st = mrrc_pkg::ST_SHORT;
        end else if ({n_held1, n_held0} != n_crc) begin
            st = mrrc_pkg::ST_CRC_ERROR;
        end else if (n_first != i_cfg.expected_slave) begin
            st = mrrc_pkg::ST_WRONG_SLAVE;
        end else if (n_second == (mrrc_pkg::EXC_FLAG |
                                  {1'b0, i_cfg.expected_function})) begin
            st       = mrrc_pkg::ST_EXCEPTION;
            exc_code = n_third;
        end else if (n_second != {1'b0, i_cfg.expected_function}) begin
            st = mrrc_pkg::ST_WRONG_FUNC;
        end else begin
            st      = mrrc_pkg::ST_OK;
            pdu_len = len_clamped;
        end

        // A frame end returns all frame state to its reset value.
        if (i_item.frame_end) begin
            n_byte_count = '0;
            n_crc        = mrrc_pkg::CRC_INIT;
            n_held0      = 8'h00;
            n_held1      = 8'h00;
            n_first      = 8'h00;
            n_second     = 8'h00;
            n_third      = 8'h00;
        end
    end

    // Result beats for the queue.
    always_comb begin
        o_push.pdu_valid               = i_consume && pdu_emit;
        o_push.status_valid            = i_consume && i_item.frame_end;
        o_push.pdu_res.pdu_byte        = r_held0;
        o_push.pdu_res.is_status       = 1'b0;
        o_push.pdu_res.status          = mrrc_pkg::ST_OK;
        o_push.pdu_res.exception_code  = 8'h00;
        o_push.pdu_res.pdu_length      = 8'h00;
        o_push.status_res.pdu_byte     = 8'h00;
        o_push.status_res.is_status    = 1'b1;
        o_push.status_res.status       = st;
        o_push.status_res.exception_code = exc_code;
        o_push.status_res.pdu_length   = pdu_len;
    end

    // Frame state registers, updated only when a byte is consumed.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_count <= '0;
            r_crc        <= mrrc_pkg::CRC_INIT;
            r_held0      <= 8'h00;
            r_held1      <= 8'h00;
            r_first      <= 8'h00;
            r_second     <= 8'h00;
            r_third      <= 8'h00;
        end else if (i_consume) begin
            r_byte_count <= n_byte_count;
            r_crc        <= n_crc;
            r_held0      <= n_held0;
            r_held1      <= n_held1;
            r_first      <= n_first;
            r_second     <= n_second;
            r_third      <= n_third;
        end
    end

    // The byte counter never runs past the counted frame length.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_byte_count <= mrrc_pkg::CNT_W'(mrrc_pkg::FRAME_BYTES))
        else $error("frame byte counter beyond frame length");

    // A consumed frame end leaves a fresh frame behind.
    a_frame_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_consume && i_item.frame_end) |=>
        (r_byte_count == '0) && (r_crc == mrrc_pkg::CRC_INIT))
        else $error("frame state not cleared after frame end");

    // A PDU beat only leaves once the slave byte has passed the hold.
    a_pdu_position: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push.pdu_valid |-> (r_byte_count >= mrrc_pkg::CNT_W'(3)))
        else $error("PDU beat emitted before function code position");

endmodule

`default_nettype wire

[sv/mrrc_out_fifo.sv]
// ----------------------------------------------------------------------------
// Modbus RTU response checker result queue
// Small register queue that takes up to two result beats per cycle and
// presents one registered beat per cycle, as the output port takes them.
// ----------------------------------------------------------------------------
`default_nettype none

module mrrc_out_fifo (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire mrrc_pkg::t_push i_push,
    output logic [mrrc_pkg::OQ_CNT_W-1:0] o_free,
    output logic                 o_valid,
    input  wire logic            i_ready,
    output mrrc_pkg::t_out       o_data
);

    mrrc_pkg::t_out                r_mem [mrrc_pkg::OQ_DEPTH];
    logic [mrrc_pkg::OQ_PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [mrrc_pkg::OQ_PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [mrrc_pkg::OQ_CNT_W-1:0] r_count, n_count;

    logic [mrrc_pkg::OQ_CNT_W-1:0] push_cnt;
    logic                          pop;
    mrrc_pkg::t_out                slot0;
    logic [mrrc_pkg::OQ_PTR_W-1:0] wr_ptr1;

    // Pack the valid beats so the first one lands at the write pointer.
    always_comb begin
        push_cnt = mrrc_pkg::OQ_CNT_W'(i_push.pdu_valid) +
                   mrrc_pkg::OQ_CNT_W'(i_push.status_valid);
        slot0    = i_push.pdu_valid ? i_push.pdu_res : i_push.status_res;
        wr_ptr1  = r_wr_ptr + mrrc_pkg::OQ_PTR_W'(1);
        pop      = o_valid && i_ready;
        n_wr_ptr = r_wr_ptr + push_cnt[mrrc_pkg::OQ_PTR_W-1:0];
        n_rd_ptr = r_rd_ptr + mrrc_pkg::OQ_PTR_W'(pop);
        n_count  = r_count + push_cnt - mrrc_pkg::OQ_CNT_W'(pop);
    end

    assign o_free  = mrrc_pkg::OQ_CNT_W'(mrrc_pkg::OQ_DEPTH) - r_count;
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];

    // Queue storage.
    always_ff @(posedge i_clk) begin
        if (push_cnt != '0) begin
            r_mem[r_wr_ptr] <= slot0;
        end
        if (i_push.pdu_valid && i_push.status_valid) begin
            r_mem[wr_ptr1] <= i_push.status_res;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // The queue never holds more beats than it has entries.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= mrrc_pkg::OQ_CNT_W'(mrrc_pkg::OQ_DEPTH))
        else $error("result queue overfilled");

    // Beats are only pushed when there is room for them.
    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push_cnt <= o_free)
        else $error("result pushed into a full queue");

    // The fill count tracks the pointer distance.
    a_ptr_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count != mrrc_pkg::OQ_CNT_W'(mrrc_pkg::OQ_DEPTH)) |->
        ((r_wr_ptr - r_rd_ptr) == r_count[mrrc_pkg::OQ_PTR_W-1:0]))
        else $error("result queue pointers out of step with count");

endmodule

`default_nettype wire

[sv/modbus_rtu_response_checker_core.sv]
// ----------------------------------------------------------------------------
// Modbus RTU response checker core
// Accepted bytes wait in the input register, their beats in the result queue.
// Throughput: one byte per cycle while the output takes beats; a frame's last
// byte can yield two beats, which the four-entry queue absorbs as bytes flow.
// Reset (synchronous, active low): registers return to slave 1, function 3,
// PDU limit 253; frame state and the result queue are cleared at once.
// ----------------------------------------------------------------------------
`default_nettype none

module modbus_rtu_response_checker_core (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_in_valid,
    output logic                 o_in_ready,
    input  wire mrrc_pkg::t_in   i_in,
    output logic                 o_out_valid,
    input  wire logic            i_out_ready,
    output mrrc_pkg::t_out       o_out,
    input  wire logic            i_cfg_valid,
    output logic                 o_cfg_ready,
    input  wire logic [1:0]      i_cfg_index,
    input  wire logic [7:0]      i_cfg_data
);

    mrrc_pkg::t_cfg r_cfg;
    logic           r_in_valid;
    mrrc_pkg::t_in  r_in;

    logic                          consume;
    logic [mrrc_pkg::OQ_CNT_W-1:0] q_free;
    mrrc_pkg::t_push               push;

    // Configuration writes are always taken.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.expected_slave    <= 8'd1;
            r_cfg.expected_function <= 7'd3;
            r_cfg.pdu_limit         <= 8'd253;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                mrrc_pkg::CFG_EXPECTED_SLAVE: begin
                    r_cfg.expected_slave <= i_cfg_data;
                end
                mrrc_pkg::CFG_EXPECTED_FUNCTION: begin
                    r_cfg.expected_function <= i_cfg_data[6:0];
                end
                mrrc_pkg::CFG_PDU_LIMIT: begin
                    r_cfg.pdu_limit <= i_cfg_data;
                end
                default: begin
                end
            endcase
        end
    end

    // Input register; the byte moves on once the queue has room for two beats.
    assign consume    = r_in_valid && (q_free >= mrrc_pkg::OQ_CNT_W'(2));
    assign o_in_ready = !r_in_valid || consume;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in;
        end
    end

    mrrc_frame u_frame (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_consume (consume),
        .i_item    (r_in),
        .i_cfg     (r_cfg),
        .o_push    (push)
    );

    mrrc_out_fifo u_out_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_free  (q_free),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_data  (o_out)
    );

endmodule

`default_nettype wire
